[design/tlb_page_translate_fifo_assert.svh]
// Assertion helpers, clocked on clk_i with reset rst_ni of the including module.
`ifndef TLB_PAGE_TRANSLATE_FIFO_ASSERT_SVH
`define TLB_PAGE_TRANSLATE_FIFO_ASSERT_SVH

// Same-cycle implication.
`define TPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tlbpt_pkg.sv]
package tlbpt_pkg;

  localparam int PageW      = 8;
  localparam int OffsetW    = 8;
  localparam int FrameW     = 8;
  localparam int VaddrW     = PageW + OffsetW;
  localparam int PaddrW     = FrameW + OffsetW;
  localparam int PageCount  = 1 << PageW;
  localparam int FrameSlots = 1 << FrameW;
  localparam int TlbEntries = 16;
  localparam int TlbIdxW    = $clog2(TlbEntries);
  localparam int FcW        = 9;
  localparam int FcReset    = 100;
  localparam int CountW     = 32;
  localparam int StatusW    = 2;
  localparam int StepW      = $clog2(FcW);

  typedef logic [PageW-1:0]   page_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef logic [FrameW-1:0]  frame_t;
  typedef logic [FcW-1:0]     fc_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CountW-1:0]  count_t;

  localparam status_t StatusTlbHit   = 2'd0;
  localparam status_t StatusTableHit = 2'd1;
  localparam status_t StatusFault    = 2'd2;

  typedef struct packed {
    logic start;
    fc_t  dividend;
    fc_t  divisor;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    fc_t  remainder;
  } rem_rsp_t;

endpackage

[design/tlbpt_if.sv]
interface tlbpt_in_if;
  import tlbpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [VaddrW-1:0]   virtual_address;
  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if;
  import tlbpt_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [PaddrW-1:0] physical_address;
  frame_t            victim_frame;
  count_t            fault_total;
  modport source (output valid, output status, output physical_address,
                  output victim_frame, output fault_total, input ready);
  modport sink (input valid, input status, input physical_address,
                input victim_frame, input fault_total, output ready);
endinterface

interface tlbpt_cfg_if;
  import tlbpt_pkg::*;
  logic valid;
  logic ready;
  fc_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tlb_page_translate_fifo.sv]
// Flow: an input transfer moves IDLE to LOOK; a TLB or page-table hit then goes to OUT,
// a page fault to DIV for the 9-step remainder of the FIFO victim pointer, then OUT.
// A new address is taken only in IDLE, one translation at a time; page-table and
// reverse-map reads each use one port of a synchronous memory.
// Reset: page and TLB valid bits and the frame fill count clear at once,
// frame_count = 100, pointers and fault count zero; no clearing pass.
module tlb_page_translate_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  tlbpt_cfg_if.sink        cfg_i,
  tlbpt_in_if.sink         in_i,
  tlbpt_out_if.source      out_o
);
  import tlbpt_pkg::*;

  `include "tlb_page_translate_fifo_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam count_t CountMax = '1;

  logic [1:0] state_q, state_d;
  fc_t        fc_q;
  frame_t     victim_ptr_q;
  logic [TlbIdxW-1:0] slot_q;
  count_t     fault_cnt_q;

  page_t      page_q;
  offset_t    offset_q;
  status_t    res_status_q;
  frame_t     res_frame_q;
  frame_t     res_victim_q;

  logic              out_valid_q;
  status_t           out_status_q;
  logic [PaddrW-1:0] out_pa_q;
  frame_t            out_victim_q;
  count_t            out_total_q;

  logic [PageCount-1:0]  pv_q, pv_d;
  logic [FrameW:0]       fill_q;
  logic [FrameW:0]       victim_ext;
  logic                  victim_used;
  frame_t pt_mem [PageCount];
  page_t  rm_mem [FrameSlots];
  frame_t pt_rd_q;
  page_t  rm_rd_q;

  logic   tlb_valid_q [TlbEntries];
  logic   tlb_valid_d [TlbEntries];
  page_t  tlb_page_q  [TlbEntries];
  frame_t tlb_frame_q [TlbEntries];

  logic     in_xfer, is_look, tlb_hit, pt_hit, fault, out_load;
  frame_t   tlb_hit_frame;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign is_look     = state_q == S_LOOK;
  assign pt_hit      = pv_q[page_q];
  assign fault       = !tlb_hit && !pt_hit;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  // victim pointer only ever steps up by one past the highest frame used so far
  assign victim_ext  = {1'b0, victim_ptr_q};
  assign victim_used = victim_ext < fill_q;

  always_comb begin
    tlb_hit       = 1'b0;
    tlb_hit_frame = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        tlb_hit       = 1'b1;
        tlb_hit_frame = tlb_frame_q[i];
      end
    end
  end

  always_comb begin
    pv_d        = pv_q;
    tlb_valid_d = tlb_valid_q;
    if (is_look && fault) begin
      if (victim_used) begin
        pv_d[rm_rd_q] = 1'b0;
      end
      pv_d[page_q] = 1'b1;
      for (int i = 0; i < TlbEntries; i++) begin
        if (tlb_frame_q[i] == victim_ptr_q) begin
          tlb_valid_d[i] = 1'b0;
        end
      end
      tlb_valid_d[slot_q] = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_LOOK;
      S_LOOK: state_d = fault ? S_DIV : S_OUT;
      S_DIV:  if (rem_rsp.done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign rem_req.start    = is_look && fault;
  assign rem_req.dividend = FcW'(victim_ptr_q) + 1'b1;
  assign rem_req.divisor  = fc_q;

  tlbpt_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fc_q         <= FcW'(FcReset);
      victim_ptr_q <= '0;
      slot_q       <= '0;
      fault_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      pv_q         <= '0;
      fill_q       <= '0;
      for (int i = 0; i < TlbEntries; i++) begin
        tlb_valid_q[i] <= 1'b0;
        tlb_page_q[i]  <= '0;
        tlb_frame_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pv_q        <= pv_d;
      tlb_valid_q <= tlb_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        fc_q <= cfg_i.data;
      end
      if (is_look && fault) begin
        if (victim_ext == fill_q) begin
          fill_q <= fill_q + 1'b1;
        end
        tlb_page_q[slot_q]  <= page_q;
        tlb_frame_q[slot_q] <= victim_ptr_q;
        slot_q              <= slot_q + 1'b1;
        if (fault_cnt_q != CountMax) begin
          fault_cnt_q <= fault_cnt_q + 1'b1;
        end
      end
      if (state_q == S_DIV && rem_rsp.done) begin
        victim_ptr_q <= (fc_q == '0) ? '0 : rem_rsp.remainder[FrameW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      page_q   <= in_i.virtual_address[VaddrW-1:OffsetW];
      offset_q <= in_i.virtual_address[OffsetW-1:0];
      pt_rd_q  <= pt_mem[in_i.virtual_address[VaddrW-1:OffsetW]];
      rm_rd_q  <= rm_mem[victim_ptr_q];
    end
    if (is_look && fault) begin
      pt_mem[page_q]       <= victim_ptr_q;
      rm_mem[victim_ptr_q] <= page_q;
    end
    if (is_look) begin
      if (tlb_hit) begin
        res_status_q <= StatusTlbHit;
        res_frame_q  <= tlb_hit_frame;
        res_victim_q <= '0;
      end else if (pt_hit) begin
        res_status_q <= StatusTableHit;
        res_frame_q  <= pt_rd_q;
        res_victim_q <= '0;
      end else begin
        res_status_q <= StatusFault;
        res_frame_q  <= victim_ptr_q;
        res_victim_q <= victim_ptr_q;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pa_q     <= {res_frame_q, offset_q};
      out_victim_q <= res_victim_q;
      out_total_q  <= fault_cnt_q;
    end
  end

  assign cfg_i.ready            = 1'b1;
  assign in_i.ready             = state_q == S_IDLE;
  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.physical_address = out_pa_q;
  assign out_o.victim_frame     = out_victim_q;
  assign out_o.fault_total      = out_total_q;

  `TPF_ASSERT_NEXT(a_fault_maps_page, is_look && fault, pv_q[$past(page_q)],
                   "faulting page not valid after mapping")
  `TPF_ASSERT_NEXT(a_fault_owns_frame, is_look && fault, $past(victim_ext) < fill_q,
                   "victim frame not counted as filled")
  `TPF_ASSERT_NOW(a_div_active, state_q == S_DIV, rem_rsp.busy || rem_rsp.done,
                  "waiting on an idle remainder unit")
  `TPF_ASSERT_NOW(a_count_monotonic, 1'b1, fault_cnt_q >= $past(fault_cnt_q),
                  "fault count went down")

endmodule

[design/tlbpt_rem.sv]
module tlbpt_rem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::rem_req_t req_i,
  output tlbpt_pkg::rem_rsp_t rsp_o
);
  import tlbpt_pkg::*;

  localparam logic [StepW-1:0] FirstStep = StepW'(FcW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  fc_t              num_q, num_d;
  fc_t              den_q, den_d;
  fc_t              rem_q, rem_d;
  logic [FcW:0]     trial;

  assign trial = {rem_q, num_q[FcW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = FirstStep;
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[FcW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = FcW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[FcW-1:0];
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tlbpt_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 30;
  localparam int Phases = 8;

  typedef struct packed {
    status_t             code;
    logic [PaddrW-1:0]   paddr;
    frame_t              victim;
    count_t              faults;
  } xlat_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlbpt_cfg_if cfg_if ();
  tlbpt_in_if  in_if ();
  tlbpt_out_if out_if ();

  tlb_page_translate_fifo dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // translation state mirror
  bit      pt_valid [PageCount];
  frame_t  pt_frame [PageCount];
  bit      tlb_v [TlbEntries];
  page_t   tlb_pg [TlbEntries];
  frame_t  tlb_fr [TlbEntries];
  frame_t  victim_ptr;
  logic [TlbIdxW-1:0] slot_ptr;
  count_t  fault_cnt;
  fc_t     frames_cfg;

  logic [VaddrW-1:0] addr_queue[$];
  xlat_result_t      xlat_expected[$];
  bit     in_busy;
  int     burst_left;
  int     gap_left;
  int     stall_hold;
  logic [15:0] stall_pattern;
  int     mismatches;
  page_t  ws_base;
  page_t  last_page;

  wire moved = (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
               (cfg_if.valid && cfg_if.ready);

  function automatic xlat_result_t translate(logic [VaddrW-1:0] va);
    page_t        pg;
    frame_t       fr;
    bit           hit;
    int           i;
    xlat_result_t r;
    pg = va[VaddrW-1:OffsetW];
    fr = '0;
    hit = 1'b0;
    r.victim = '0;
    // scan downward so the lowest matching index wins
    for (i = TlbEntries - 1; i >= 0; i--) begin
      if (tlb_v[i] && tlb_pg[i] == pg) begin
        hit = 1'b1;
        fr = tlb_fr[i];
      end
    end
    if (hit) begin
      r.code = StatusTlbHit;
    end else if (pt_valid[pg]) begin
      fr = pt_frame[pg];
      r.code = StatusTableHit;
    end else begin
      r.code = StatusFault;
      if (fault_cnt != '1) fault_cnt++;
      fr = victim_ptr;
      r.victim = victim_ptr;
      for (i = 0; i < PageCount; i++) if (pt_frame[i] == fr) pt_valid[i] = 1'b0;
      for (i = 0; i < TlbEntries; i++) if (tlb_fr[i] == fr) tlb_v[i] = 1'b0;
      pt_frame[pg] = fr;
      pt_valid[pg] = 1'b1;
      tlb_v[slot_ptr] = 1'b1;
      tlb_fr[slot_ptr] = fr;
      tlb_pg[slot_ptr] = pg;
      slot_ptr++;
      victim_ptr = (frames_cfg == '0) ? '0 : frame_t'((int'(fr) + 1) % int'(frames_cfg));
    end
    r.paddr = {fr, va[OffsetW-1:0]};
    r.faults = fault_cnt;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [VaddrW-1:0] pick_address(int span);
    page_t pg;
    int    r;
    r = $urandom_range(99);
    if (r < 15) pg = page_t'($urandom);
    else if (r < 40) pg = last_page;
    else pg = page_t'(ws_base + $urandom_range(span));
    last_page = pg;
    return {pg, offset_t'($urandom_range(255))};
  endfunction

  task automatic set_frame_count(fc_t value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    frames_cfg = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (addr_queue.size() != 0 || in_busy || xlat_expected.size() != 0) @(posedge clk_i);
  endtask

  // address driver: bursts with gaps
  always @(negedge clk_i) begin
    if (rst_ni && !in_busy) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (burst_left > 0 && addr_queue.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.virtual_address <= addr_queue.pop_front();
        in_busy = 1'b1;
        burst_left--;
      end else begin
        in_if.valid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      xlat_expected.push_back(translate(in_if.virtual_address));
      in_busy = 1'b0;
    end
  end

  // result-side backpressure
  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_hold = $urandom_range(20, 120);
      stall_pattern = ($urandom_range(3) == 0) ? '1 : (16'($urandom) | 16'h1);
    end
    stall_hold--;
    out_if.ready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
  end

  always @(posedge clk_i) begin : result_check
    xlat_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (xlat_expected.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = xlat_expected.pop_front();
        check_field("status", 32'(want.code), 32'(out_if.status));
        check_field("physical_address", 32'(want.paddr), 32'(out_if.physical_address));
        check_field("victim_frame", 32'(want.victim), 32'(out_if.victim_frame));
        check_field("fault_total", want.faults, out_if.fault_total);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if (moved) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    fc_t phase_fc [Phases];
    int  phase_len [Phases];
    int  phase_span [Phases];
    int  p;
    int  n;
    phase_fc   = '{9'd100, 9'd1, 9'd0, 9'd256, 9'd7, 9'd511, 9'd2, 9'd100};
    phase_len  = '{300, 150, 100, 350, 150, 400, 100, 250};
    phase_span = '{31, 15, 15, 63, 31, 255, 7, 47};
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.virtual_address = '0;
    out_if.ready = 1'b0;
    frames_cfg = fc_t'(FcReset);
    victim_ptr = '0;
    slot_ptr = '0;
    fault_cnt = '0;
    last_page = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // address extremes, TLB hits, then wrap the TLB fill pointer so
    // page 0 falls back to a page-table hit
    addr_queue.push_back(16'h0000);
    addr_queue.push_back(16'hFFFF);
    addr_queue.push_back(16'hFF00);
    addr_queue.push_back(16'h00FF);
    for (n = 1; n <= 15; n++) addr_queue.push_back({page_t'(n), offset_t'(n * 17)});
    addr_queue.push_back(16'h0042);
    addr_queue.push_back(16'hFF80);
    addr_queue.push_back(16'h8000);
    drain();

    for (p = 0; p < Phases; p++) begin
      set_frame_count(phase_fc[p]);
      ws_base = page_t'($urandom);
      for (n = 0; n < phase_len[p]; n++) addr_queue.push_back(pick_address(phase_span[p]));
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tlbpt_pkg.sv
design/tlbpt_if.sv
design/tlbpt_rem.sv
design/tlb_page_translate_fifo.sv
verif/tb_top.sv
